// File: hw/rtl/linear_interp_resampler_core_defines.svh
// assertion helpers used by the checker in lir_checker.sv
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// condition on this edge implies consequence on the same edge
`define LIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition on this edge implies consequence on the next edge
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lir_pkg.sv
package lir_pkg;

  localparam int STEP_W     = 21;
  localparam int COUNT_W    = 27;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 1'b1;

  localparam logic [STEP_W-1:0]  PHASE_STEP_RST   = 21'd65536;
  localparam logic [COUNT_W-1:0] OUTPUT_COUNT_RST = 27'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTERP_CHK,
    ST_INTERP_EMIT,
    ST_ADVANCE,
    ST_HELD,
    ST_ZERO,
    ST_CLEAR,
    ST_FLUSH
  } lir_state_e;

  typedef enum logic [1:0] {
    EMIT_INTERP,
    EMIT_HELD,
    EMIT_ZERO
  } lir_emit_sel_e;

  typedef struct packed {
    logic          load;
    logic          mul;
    logic          emit;
    lir_emit_sel_e sel;
    logic          advance;
    logic          clear;
    logic          flush;
  } lir_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic fin;
    logic match_cur;
    logic match_beyond;
    logic slot_ok;
    logic out_free;
    logic pend_valid;
  } lir_status_t;

endpackage

// File: hw/rtl/lir_ctrl.sv
module lir_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lir_pkg::lir_status_t status_i,
  output lir_pkg::lir_cmd_t    cmd_o
);
  import lir_pkg::*;

  lir_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.have_prev ? ST_INTERP_CHK : ST_ADVANCE;
        end
      end
      ST_INTERP_CHK: begin
        state_d = status_i.match_cur ? ST_INTERP_EMIT : ST_ADVANCE;
      end
      ST_INTERP_EMIT: begin
        if (status_i.slot_ok) begin
          state_d = ST_INTERP_CHK;
        end
      end
      ST_ADVANCE: begin
        state_d = status_i.fin ? ST_HELD : ST_FLUSH;
      end
      ST_HELD: begin
        if (!status_i.match_cur) begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (!status_i.match_beyond) begin
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = EMIT_INTERP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_INTERP_CHK: begin
        cmd_o.mul = status_i.match_cur;
      end
      ST_INTERP_EMIT: begin
        cmd_o.emit = status_i.slot_ok;
      end
      ST_ADVANCE: begin
        cmd_o.advance = 1'b1;
      end
      ST_HELD: begin
        cmd_o.sel  = EMIT_HELD;
        cmd_o.emit = status_i.match_cur && status_i.slot_ok;
      end
      ST_ZERO: begin
        cmd_o.sel  = EMIT_ZERO;
        cmd_o.emit = status_i.match_beyond && status_i.slot_ok;
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_FLUSH: begin
        cmd_o.flush = status_i.pend_valid && status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/lir_dp.sv
module lir_dp #(
  parameter int SAMPLE_BITS  = 16,
  parameter int FRAC_BITS    = 16,
  parameter int INDEX_BITS   = 24,
  parameter int MAX_UPSAMPLE = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lir_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lir_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]           in_sample_i,
  input  logic                             in_final_i,
  input  lir_pkg::lir_cmd_t                cmd_i,
  output lir_pkg::lir_status_t             status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [SAMPLE_BITS-1:0]           out_sample_o,
  output logic                             out_run_end_o,
  output logic                             out_done_o
);
  import lir_pkg::*;

  localparam int POS_W      = INDEX_BITS + FRAC_BITS;
  localparam int MAX_RES    = 3 * MAX_UPSAMPLE;
  localparam int KW         = $clog2(MAX_RES + 1);
  localparam int STEP_MIN_V = (1 << FRAC_BITS) / MAX_UPSAMPLE;
  localparam int STEP_EW    = (FRAC_BITS + 1 > STEP_W) ? FRAC_BITS + 1 : STEP_W;
  localparam int DIFF_W     = SAMPLE_BITS + 1;
  localparam int PROD_W     = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int Q_W        = PROD_W - FRAC_BITS;
  localparam int SUM_W      = SAMPLE_BITS + 3;

  localparam logic [STEP_EW-1:0] STEP_MIN   = STEP_EW'(STEP_MIN_V);
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = $signed({4'b0000, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = $signed({4'b1111, {(SAMPLE_BITS-1){1'b0}}});

  // configuration
  logic [STEP_W-1:0]  phase_step_q;
  logic [COUNT_W-1:0] output_count_q;

  // item payload
  logic [SAMPLE_BITS-1:0] cur_q;
  logic                   fin_q;

  // resampler state
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic                   have_prev_q, have_prev_d;
  logic [INDEX_BITS-1:0]  in_index_q, in_index_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [COUNT_W-1:0]     emitted_q, emitted_d;
  logic [KW-1:0]          k_q, k_d;

  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic [SAMPLE_BITS-1:0] pend_data_q;
  logic                   pend_done_q;
  logic                   pend_valid_q, pend_valid_d;

  logic [SAMPLE_BITS-1:0] out_data_q;
  logic                   out_last_q, out_user_q;
  logic                   out_valid_q, out_valid_d;

  logic [STEP_EW-1:0]       step_raw, step_eff;
  logic [INDEX_BITS-1:0]    pos_idx, beyond_idx;
  logic                     room;
  logic                     out_free;
  logic                     push;
  logic signed [DIFF_W-1:0] diff;
  logic [FRAC_BITS-1:0]     frac;
  logic signed [PROD_W-1:0] rnd;
  logic signed [Q_W-1:0]    q;
  logic signed [SUM_W-1:0]  sum;
  logic [SAMPLE_BITS-1:0]   interp_val;
  logic [SAMPLE_BITS-1:0]   emit_val;
  logic [COUNT_W-1:0]       emitted_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= PHASE_STEP_RST;
      output_count_q <= OUTPUT_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_OUTPUT_COUNT: output_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign step_raw = STEP_EW'(phase_step_q);
  assign step_eff = (step_raw < STEP_MIN) ? STEP_MIN : step_raw;

  assign pos_idx     = pos_q[POS_W-1:FRAC_BITS];
  assign beyond_idx  = in_index_q + INDEX_BITS'(1);
  assign room        = (emitted_q < output_count_q) && (k_q < KW'(MAX_RES));
  assign out_free    = !out_valid_q || out_ready_i;
  assign emitted_inc = emitted_q + COUNT_W'(1);

  // multiply stage: (cur - prev) * frac
  assign frac   = pos_q[FRAC_BITS-1:0];
  assign diff   = $signed({cur_q[SAMPLE_BITS-1], cur_q}) - $signed({prev_q[SAMPLE_BITS-1], prev_q});
  assign prod_d = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));

  // round half up, add, saturate
  assign rnd = prod_q + $signed(ROUND_HALF);
  assign q   = rnd[PROD_W-1:FRAC_BITS];
  assign sum = SUM_W'($signed(prev_q)) + SUM_W'(q);

  always_comb begin
    if (sum > SAT_HI) begin
      interp_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sum < SAT_LO) begin
      interp_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      interp_val = sum[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      EMIT_INTERP: emit_val = interp_val;
      EMIT_HELD:   emit_val = prev_q;
      EMIT_ZERO:   emit_val = '0;
      default:     emit_val = '0;
    endcase
  end

  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    in_index_d  = in_index_q;
    pos_d       = pos_q;
    emitted_d   = emitted_q;
    k_d         = k_q;
    priority if (cmd_i.load) begin
      k_d = '0;
    end else if (cmd_i.emit) begin
      emitted_d = emitted_inc;
      pos_d     = pos_q + POS_W'(step_eff);
      k_d       = k_q + KW'(1);
    end else if (cmd_i.advance) begin
      if (have_prev_q) begin
        in_index_d = in_index_q + INDEX_BITS'(1);
      end
      prev_d      = cur_q;
      have_prev_d = 1'b1;
    end else if (cmd_i.clear) begin
      prev_d      = '0;
      have_prev_d = 1'b0;
      in_index_d  = '0;
      pos_d       = '0;
      emitted_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      in_index_q  <= '0;
      pos_q       <= '0;
      emitted_q   <= '0;
      k_q         <= '0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      in_index_q  <= in_index_d;
      pos_q       <= pos_d;
      emitted_q   <= emitted_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= in_sample_i;
      fin_q <= in_final_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.emit) begin
      pend_data_q <= emit_val;
      pend_done_q <= (emitted_inc == output_count_q);
    end
    if (push) begin
      out_data_q <= pend_data_q;
      out_last_q <= cmd_i.flush;
      out_user_q <= pend_done_q;
    end
  end

  // a new word moves the held one forward; run_end is known only on flush
  assign push         = (cmd_i.emit && pend_valid_q) || cmd_i.flush;
  assign pend_valid_d = cmd_i.emit ? 1'b1 : (cmd_i.flush ? 1'b0 : pend_valid_q);
  assign out_valid_d  = push || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign status_o.have_prev    = have_prev_q;
  assign status_o.fin          = fin_q;
  assign status_o.match_cur    = room && (pos_idx == in_index_q);
  assign status_o.match_beyond = room && (pos_idx == beyond_idx);
  assign status_o.slot_ok      = !pend_valid_q || out_free;
  assign status_o.out_free     = out_free;
  assign status_o.pend_valid   = pend_valid_q;

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_data_q;
  assign out_run_end_o = out_last_q;
  assign out_done_o    = out_user_q;

endmodule

// File: hw/rtl/linear_interp_resampler_core.sv
// one input word at a time; a word after the first of a buffer loads, then emits each
// interpolated output through the registered multiplier; a first word only advances
// a final word then emits held and zero outputs and clears; output stalls hold the item
// the last word of an item is held back until the item ends, so it carries run_end
// rst_ni is asynchronous active low: clears state, phase_step to 1.0, output_count to 0
module linear_interp_resampler_core #(
  parameter int SAMPLE_BITS  = 16,
  parameter int FRAC_BITS    = 16,
  parameter int INDEX_BITS   = 24,
  parameter int MAX_UPSAMPLE = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // sample_in
  input  logic                           s_axis_tlast,  // final_sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // sample_out
  output logic                           m_axis_tlast,  // run_end
  output logic                           m_axis_tuser   // stream_done
);
  import lir_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  lir_cmd_t               cmd;
  lir_status_t            status;
  logic [SAMPLE_BITS-1:0] out_sample;

  lir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lir_dp #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .INDEX_BITS   (INDEX_BITS),
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_final_i    (s_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_sample_o  (out_sample),
    .out_run_end_o (m_axis_tlast),
    .out_done_o    (m_axis_tuser)
  );

  assign m_axis_tdata = TDATA_W'(out_sample);

endmodule

// File: hw/rtl/lir_checker.sv
`include "linear_interp_resampler_core_defines.svh"

module lir_checker #(
  parameter int TDATA_W = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast,
  input logic               m_axis_tuser
);

  `LIR_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")
  `LIR_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output word changed while stalled")
  `LIR_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")
  `LIR_ASSERT_NOW(a_done_ends_run, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "stream_done word not last of its item")

endmodule

bind linear_interp_resampler_core lir_checker #(
  .TDATA_W (TDATA_W)
) u_lir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: bench/lir_resampler_checker.sv
`timescale 1ns / 1ps

module lir_resampler_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,   // sample_in
  input  logic                           s_axis_tlast,   // final_sample
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [15:0]                    m_axis_tdata,   // sample_out
  input  logic                           m_axis_tlast,   // run_end
  input  logic                           m_axis_tuser,   // stream_done
  output int                             mismatch_count_o,
  output int                             backlog_o,
  output int                             words_checked_o
);

  localparam logic [20:0] STEP_FLOOR = 21'((2 ** 16) / 8);
  localparam int          ITEM_CAP   = 24;

  typedef struct packed {
    logic [15:0] sample;
    logic        run_end;
    logic        done;
  } out_word_t;

  logic [20:0] step_q;
  logic [26:0] count_q;
  logic [15:0] held_q;
  bit          primed_q;
  logic [23:0] src_idx_q;
  logic [39:0] pos_q;
  logic [26:0] produced_q;

  out_word_t pending_words[$];
  out_word_t item_words[$];
  int        mismatches;
  int        checked;

  // prev + (cur - prev) * frac, rounded half up, saturated
  function automatic logic [15:0] lerp_q15(logic [15:0] a, logic [15:0] b, logic [15:0] frac);
    longint t;
    longint v;
    t = (longint'($signed(b)) - longint'($signed(a))) * longint'(frac) + 32768;
    v = longint'($signed(a)) + (t >>> 16);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void put_word(logic [15:0] v);
    out_word_t w;
    produced_q  = produced_q + 27'd1;
    w.sample    = v;
    w.run_end   = 1'b0;
    w.done      = (produced_q == count_q);
    item_words.push_back(w);
    pos_q = pos_q + 40'((step_q < STEP_FLOOR) ? STEP_FLOOR : step_q);
  endfunction

  function automatic void resample_word(logic [15:0] cur, logic fin);
    logic [23:0] beyond;
    out_word_t   w;
    item_words.delete();
    if (primed_q) begin
      while (item_words.size() < ITEM_CAP && produced_q < count_q && pos_q[39:16] == src_idx_q)
        put_word(lerp_q15(held_q, cur, pos_q[15:0]));
      src_idx_q = src_idx_q + 24'd1;
    end
    primed_q = 1'b1;
    held_q   = cur;
    if (fin) begin
      beyond = src_idx_q + 24'd1;
      while (item_words.size() < ITEM_CAP && produced_q < count_q && pos_q[39:16] == src_idx_q)
        put_word(held_q);
      while (item_words.size() < ITEM_CAP && produced_q < count_q && pos_q[39:16] == beyond)
        put_word(16'd0);
      held_q     = '0;
      primed_q   = 1'b0;
      src_idx_q  = '0;
      pos_q      = '0;
      produced_q = '0;
    end
    foreach (item_words[i]) begin
      w         = item_words[i];
      w.run_end = (i == item_words.size() - 1);
      pending_words.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    out_word_t got;
    if (!rst_ni) begin
      step_q     = lir_pkg::PHASE_STEP_RST;
      count_q    = lir_pkg::OUTPUT_COUNT_RST;
      held_q     = '0;
      primed_q   = 1'b0;
      src_idx_q  = '0;
      pos_q      = '0;
      produced_q = '0;
      pending_words.delete();
      mismatches = 0;
      checked    = 0;
      mismatch_count_o <= 0;
      backlog_o        <= 0;
      words_checked_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
        if (pending_words.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word: sample %0d run_end %0b done %0b",
                     $realtime, $signed(got.sample), got.run_end, got.done);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected sample %0d run_end %0b done %0b, got sample %0d run_end %0b done %0b",
                       $realtime, $signed(want.sample), want.run_end, want.done,
                       $signed(got.sample), got.run_end, got.done);
            mismatches++;
          end
        end
        checked++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lir_pkg::CFG_PHASE_STEP:   step_q  = cfg_data_i[20:0];
          lir_pkg::CFG_OUTPUT_COUNT: count_q = cfg_data_i[26:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        resample_word(s_axis_tdata, s_axis_tlast);
      mismatch_count_o <= mismatches;
      backlog_o        <= pending_words.size();
      words_checked_o  <= checked;
    end
  end

endmodule

// File: bench/tb_linear_interp_resampler_core.sv
`timescale 1ns / 1ps

module tb_linear_interp_resampler_core;
  import lir_pkg::*;

  localparam int     CLK_HALF      = 10;
  localparam longint LIMIT_CYCLES  = 2_000_000;
  localparam int     SETTLE_CYCLES = 120;
  localparam int     RANDOM_WORDS  = 400;
  localparam int     STEP_FLOOR    = 8192;
  localparam int     STEP_UNITY    = 65536;
  localparam int     STEP_DOWN16   = 1048576;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_PHASE_STEP;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;  // sample_in
  logic                  s_axis_tlast  = 1'b0;  // final_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;  // sample_out
  logic                  m_axis_tlast;  // run_end
  logic                  m_axis_tuser;  // stream_done

  bit          steady_out = 1'b0;
  int unsigned stall_left = 0;
  longint      cycles     = 0;
  int          words_sent = 0;
  int          buffers    = 0;
  int          mismatches;
  int          backlog;
  int          checked;

  linear_interp_resampler_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  lir_resampler_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatches),
    .backlog_o        (backlog),
    .words_checked_o  (checked)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (steady_out) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= gap_len();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("linear_interp_resampler_core regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [15:0] s, input logic fin, input bit quiet);
    int unsigned g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // wait for every expected word, then for any result-free item still in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [26:0] step_word, input logic [26:0] count_word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PHASE_STEP;
    cfg_data_i <= step_word;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OUTPUT_COUNT;
    cfg_data_i <= count_word;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_random_buffer(input bit first);
    int          n;
    int          r;
    int          walk;
    int          eff;
    longint      want;
    logic [20:0] step;
    logic [26:0] step_word;
    logic [26:0] count_word;
    logic [15:0] s;
    bit          quiet;
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 60);
    r = $urandom_range(0, 99);
    if (r < 15) step = 21'(STEP_FLOOR);
    else if (r < 25) step = 21'(STEP_DOWN16);
    else if (r < 35) step = 21'(STEP_UNITY);
    else if (r < 45) step = 21'd60211;  // 44.1k to 48k
    else if (r < 55) step = 21'($urandom_range(0, STEP_FLOOR - 1));
    else if (r < 60) step = 21'($urandom_range(STEP_DOWN16 + 1, 2097151));
    else step = 21'($urandom_range(STEP_FLOOR, STEP_DOWN16));
    eff  = (step < STEP_FLOOR) ? STEP_FLOOR : int'(step);
    want = (longint'(n) * 131072 + eff) / (2 * longint'(eff));
    r = $urandom_range(0, 99);
    if (r < 60) count_word = 27'(want);
    else if (r < 75) count_word = 27'((want + $urandom_range(0, 6) > 3) ?
                                      want + $urandom_range(0, 6) - 3 : 0);
    else if (r < 85) count_word = 27'($urandom_range(0, n));
    else if (r < 95) count_word = 27'($urandom_range(0, 134217727));
    else count_word = 27'd134217727;
    step_word = {6'd0, step};
    if ($urandom_range(0, 9) == 0) step_word[26:21] = 6'($urandom);
    // sometimes keep the old setting and start the next buffer back to back
    if (first || $urandom_range(0, 2) != 0) begin
      settle();
      program_regs(step_word, count_word);
    end
    quiet      = ($urandom_range(0, 3) == 0);
    steady_out <= quiet;
    walk = int'($signed(16'($urandom)));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        walk = walk + int'($urandom_range(0, 4000)) - 2000;
        if (walk > 32767) walk = 32767;
        if (walk < -32768) walk = -32768;
        s = 16'(walk);
      end else if (r < 90) begin
        s = 16'($urandom);
      end else begin
        case ($urandom_range(0, 4))
          0: s = 16'h7fff;
          1: s = 16'h8000;
          2: s = 16'h0000;
          3: s = 16'hffff;
          default: s = 16'h0001;
        endcase
      end
      send_word(s, i == n - 1, quiet);
    end
    buffers++;
  endtask

  initial begin
    int directed;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting, count zero: nothing may come out
    send_word(16'd1000, 1'b0, 1'b0);
    send_word(-16'sd1000, 1'b1, 1'b0);
    buffers++;
    settle();

    // unity step, full-scale swing
    program_regs(27'(STEP_UNITY), 27'd3);
    send_word(16'h7fff, 1'b0, 1'b0);
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b1, 1'b0);
    buffers++;
    settle();

    // one-sample buffer: held value, then zeros one index past
    program_regs(27'd32768, 27'd4);
    send_word(16'd12345, 1'b1, 1'b0);
    buffers++;
    settle();

    // zero step clamps to 8x, the last item emits the full 24
    program_regs(27'd0, 27'd24);
    send_word(16'h7fff, 1'b0, 1'b1);
    send_word(16'h8000, 1'b1, 1'b1);
    buffers++;
    settle();

    // rounding ties at half steps, count reached before the zero outputs
    program_regs(27'(STEP_FLOOR - 1), 27'd40);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0001, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hffff, 1'b0, 1'b0);
    send_word(16'h0001, 1'b1, 1'b0);
    buffers++;
    settle();

    // 16x down with junk above the step field, count not reached
    program_regs({6'h2a, 21'(STEP_DOWN16)}, 27'd2);
    for (int i = 0; i < 8; i++)
      send_word((i % 2) ? 16'h8000 : 16'h7fff, i == 7, 1'b0);
    buffers++;
    settle();

    // largest step, largest count
    program_regs(27'h1fffff, 27'd134217727);
    for (int i = 0; i < 5; i++)
      send_word(16'($urandom), i == 4, 1'b0);
    buffers++;

    directed = words_sent;
    run_random_buffer(1'b1);
    while (words_sent < directed + RANDOM_WORDS)
      run_random_buffer(1'b0);

    settle();
    $display("covered %0d input words in %0d buffers, %0d output words checked",
             words_sent, buffers, checked);
    $display("steps from below the 8x floor to the field maximum, counts from zero to full scale");
    if (mismatches == 0 && backlog == 0) begin
      $display("linear_interp_resampler_core regression: pass");
    end else begin
      $display("linear_interp_resampler_core regression: fail");
    end
    $finish;
  end

endmodule
